/* rtl/ptw_pkg.sv */
// Shared types, codes and field widths of the page table walker.
package ptw_pkg;

  // Field widths of the request and result ports
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 20;
  localparam int TABLE_W   = 2;
  localparam int INDEX_W   = 10;
  localparam int VALUE_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int FRAME_W   = 16;
  localparam int LEVEL_W   = 2;
  localparam int PAGE_W    = 10;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOOKUP      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET_PRESENT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SET_FRAME   = 2'd2;

  // Update targets
  localparam logic [TABLE_W-1:0] TBL_TOP  = 2'd0;
  localparam logic [TABLE_W-1:0] TBL_MID  = 2'd1;
  localparam logic [TABLE_W-1:0] TBL_LEAF = 2'd2;

  // Result status
  localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UPDATE = 2'd2;

  // Fault levels
  localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_LEAF = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_RESOLVE,
    S_UPDATE
  } ptw_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic resolve;
    logic update;
  } ptw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic req_lookup;
  } ptw_sts_t;

endpackage

/* rtl/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ptw_ctrl.sv */
// Sequencer of the page table walker: clearing pass, lookup and update steps.
module ptw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ptw_pkg::ptw_sts_t sts_i,
  output ptw_pkg::ptw_cmd_t cmd_o,
  output logic              busy_o
);

  ptw_pkg::ptw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptw_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ptw_pkg::S_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = sts_i.req_lookup ? ptw_pkg::S_READ : ptw_pkg::S_UPDATE;
        end
      end
      ptw_pkg::S_READ:    state_d = ptw_pkg::S_RESOLVE;
      ptw_pkg::S_RESOLVE: state_d = ptw_pkg::S_IDLE;
      ptw_pkg::S_UPDATE:  state_d = ptw_pkg::S_IDLE;
      default:            state_d = ptw_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ptw_pkg::S_CLEAR:   cmd_o.clear_en = 1'b1;
      ptw_pkg::S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ptw_pkg::S_READ:    cmd_o = '0;
      ptw_pkg::S_RESOLVE: cmd_o.resolve = 1'b1;
      ptw_pkg::S_UPDATE:  cmd_o.update = 1'b1;
      default:            cmd_o = '0;
    endcase
  end

  // A request taken in idle always starts work on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && state_q != ptw_pkg::S_CLEAR))
    else $error("accepted request did not start work");

endmodule

/* rtl/ptw_dpath.sv */
// Datapath of the page table walker: request registers, table RAMs, walk resolve.
module ptw_dpath #(
  parameter int TOP_INDEX_BITS  = 2,
  parameter int MID_INDEX_BITS  = 4,
  parameter int LEAF_INDEX_BITS = 4,
  parameter int OFFSET_BITS     = 10,
  parameter int FRAME_BITS      = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptw_pkg::ptw_cmd_t                cmd_i,
  output ptw_pkg::ptw_sts_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic [ptw_pkg::MODE_W-1:0]       mode_i,
  input  logic [ptw_pkg::ADDR_W-1:0]       address_i,
  input  logic                             write_access_i,
  input  logic [ptw_pkg::TABLE_W-1:0]      target_table_i,
  input  logic [ptw_pkg::INDEX_W-1:0]      entry_index_i,
  input  logic [ptw_pkg::VALUE_W-1:0]      entry_value_i,
  output logic                             done_o,
  output logic [ptw_pkg::STATUS_W-1:0]     status_o,
  output logic [ptw_pkg::FRAME_W-1:0]      frame_o,
  output logic [ptw_pkg::LEVEL_W-1:0]      fault_level_o,
  output logic [ptw_pkg::PAGE_W-1:0]       fault_page_o,
  output logic                             write_denied_o
);

  localparam int TW      = TOP_INDEX_BITS;
  localparam int MW      = TOP_INDEX_BITS + MID_INDEX_BITS;
  localparam int LW      = TOP_INDEX_BITS + MID_INDEX_BITS + LEAF_INDEX_BITS;
  localparam int VW      = ptw_pkg::VALUE_W;
  localparam int FW      = (FRAME_BITS < VW) ? FRAME_BITS : VW;
  localparam int AXW     = ptw_pkg::ADDR_W + LW;
  localparam int IXW     = ptw_pkg::INDEX_W + LW;
  localparam int FOUT_W  = ptw_pkg::FRAME_W;
  localparam int PAGE_OW = ptw_pkg::PAGE_W;

  // Request registers
  logic [ptw_pkg::MODE_W-1:0]  mode_q;
  logic                        wr_q;
  logic [ptw_pkg::TABLE_W-1:0] tgt_q;
  logic [ptw_pkg::INDEX_W-1:0] idx_q;
  logic [VW-1:0]               val_q;
  logic [LW-1:0]               walk_page_q;

  logic [AXW-1:0] addr_x;
  logic [IXW-1:0] idx_x;

  logic          leaf_writable_q;
  logic [LW-1:0] clr_cnt_q;

  // RAM ports
  logic          top_we, mid_we, leafp_we, leaff_we;
  logic [TW-1:0] top_waddr;
  logic [MW-1:0] mid_waddr;
  logic [LW-1:0] leaf_waddr;
  logic          pres_wdata;
  logic [FW-1:0] frame_wdata;
  logic          top_rdata, mid_rdata, leafp_rdata;
  logic [FW-1:0] leaff_rdata;
  logic          top_ok, mid_ok, leaf_ok;

  // Result
  logic                          done_q;
  logic [ptw_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [FOUT_W-1:0]             frame_q, frame_d;
  logic [ptw_pkg::LEVEL_W-1:0]   level_q, level_d;
  logic [PAGE_OW-1:0]            fpage_q, fpage_d;
  logic                          denied_q, denied_d;

  assign addr_x = {{LW{1'b0}}, address_i};
  assign idx_x  = {{LW{1'b0}}, idx_q};

  assign sts_o.clear_last = &clr_cnt_q;
  assign sts_o.req_lookup = (mode_i == ptw_pkg::MODE_LOOKUP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      wr_q        <= write_access_i;
      tgt_q       <= target_table_i;
      idx_q       <= entry_index_i;
      val_q       <= entry_value_i;
      walk_page_q <= addr_x[OFFSET_BITS +: LW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_writable_q <= 1'b1;
      clr_cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        leaf_writable_q <= cfg_wdata_i;
      end
      if (cmd_i.clear_en) begin
        clr_cnt_q <= clr_cnt_q + LW'(1);
      end
    end
  end

  // Drop updates whose index lies beyond the target table
  assign top_ok  = (idx_x[IXW-1:TW] == '0);
  assign mid_ok  = (idx_x[IXW-1:MW] == '0);
  assign leaf_ok = (idx_x[IXW-1:LW] == '0);

  always_comb begin
    if (cmd_i.clear_en) begin
      top_we      = 1'b1;
      mid_we      = 1'b1;
      leafp_we    = 1'b1;
      leaff_we    = 1'b1;
      top_waddr   = clr_cnt_q[TW-1:0];
      mid_waddr   = clr_cnt_q[MW-1:0];
      leaf_waddr  = clr_cnt_q;
      pres_wdata  = 1'b0;
      frame_wdata = '0;
    end else begin
      top_we      = cmd_i.update && mode_q == ptw_pkg::MODE_SET_PRESENT &&
                    tgt_q == ptw_pkg::TBL_TOP && top_ok;
      mid_we      = cmd_i.update && mode_q == ptw_pkg::MODE_SET_PRESENT &&
                    tgt_q == ptw_pkg::TBL_MID && mid_ok;
      leafp_we    = cmd_i.update && mode_q == ptw_pkg::MODE_SET_PRESENT &&
                    tgt_q == ptw_pkg::TBL_LEAF && leaf_ok;
      // Only leaf frames reach a result, so only they are stored
      leaff_we    = cmd_i.update && mode_q == ptw_pkg::MODE_SET_FRAME &&
                    tgt_q == ptw_pkg::TBL_LEAF && leaf_ok;
      top_waddr   = idx_x[TW-1:0];
      mid_waddr   = idx_x[MW-1:0];
      leaf_waddr  = idx_x[LW-1:0];
      pres_wdata  = val_q[0];
      frame_wdata = val_q[FW-1:0];
    end
  end

  ptw_ram #(.WIDTH(1), .DEPTH(1 << TW)) u_top_present (
    .clk_i   (clk_i),
    .we_i    (top_we),
    .waddr_i (top_waddr),
    .wdata_i (pres_wdata),
    .raddr_i (walk_page_q[LW-1 -: TW]),
    .rdata_o (top_rdata)
  );

  ptw_ram #(.WIDTH(1), .DEPTH(1 << MW)) u_mid_present (
    .clk_i   (clk_i),
    .we_i    (mid_we),
    .waddr_i (mid_waddr),
    .wdata_i (pres_wdata),
    .raddr_i (walk_page_q[LW-1 -: MW]),
    .rdata_o (mid_rdata)
  );

  ptw_ram #(.WIDTH(1), .DEPTH(1 << LW)) u_leaf_present (
    .clk_i   (clk_i),
    .we_i    (leafp_we),
    .waddr_i (leaf_waddr),
    .wdata_i (pres_wdata),
    .raddr_i (walk_page_q),
    .rdata_o (leafp_rdata)
  );

  ptw_ram #(.WIDTH(FW), .DEPTH(1 << LW)) u_leaf_frame (
    .clk_i   (clk_i),
    .we_i    (leaff_we),
    .waddr_i (leaf_waddr),
    .wdata_i (frame_wdata),
    .raddr_i (walk_page_q),
    .rdata_o (leaff_rdata)
  );

  // Resolve the walk, or mark an update done: first absent level wins
  always_comb begin
    status_d = ptw_pkg::ST_FOUND;
    frame_d  = '0;
    level_d  = ptw_pkg::LVL_NONE;
    fpage_d  = '0;
    denied_d = 1'b0;
    if (cmd_i.update) begin
      status_d = ptw_pkg::ST_UPDATE;
    end else if (!top_rdata) begin
      status_d = ptw_pkg::ST_FAULT;
      level_d  = ptw_pkg::LVL_TOP;
      fpage_d  = PAGE_OW'(walk_page_q[LW-1 -: TW]);
    end else if (!mid_rdata) begin
      status_d = ptw_pkg::ST_FAULT;
      level_d  = ptw_pkg::LVL_MID;
      fpage_d  = PAGE_OW'(walk_page_q[LW-1 -: MW]);
    end else if (!leafp_rdata) begin
      status_d = ptw_pkg::ST_FAULT;
      level_d  = ptw_pkg::LVL_LEAF;
      fpage_d  = PAGE_OW'(walk_page_q);
    end else begin
      frame_d  = FOUT_W'(leaff_rdata);
      denied_d = wr_q && !leaf_writable_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve || cmd_i.update) begin
      status_q <= status_d;
      frame_q  <= frame_d;
      level_q  <= level_d;
      fpage_q  <= fpage_d;
      denied_q <= denied_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.resolve || cmd_i.update;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign frame_o        = frame_q;
  assign fault_level_o  = level_q;
  assign fault_page_o   = fpage_q;
  assign write_denied_o = denied_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ptw_pkg::ST_FOUND) |->
      (level_q == ptw_pkg::LVL_NONE && fpage_q == '0))
    else $error("translation carries fault fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ptw_pkg::ST_FAULT) |-> (frame_q == '0 && !denied_q))
    else $error("fault carries a frame or a write denial");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == ptw_pkg::ST_UPDATE) |->
      (frame_q == '0 && !denied_q && level_q == ptw_pkg::LVL_NONE && fpage_q == '0))
    else $error("update result not clean");

endmodule

/* rtl/three_level_page_table_walker_unit.sv */
// Three-level page table walker: top level joining sequencer and datapath.
//
// After reset the block sweeps its table RAMs to clear every present bit and
// frame, one entry a cycle, over all 2**(TOP_INDEX_BITS+MID_INDEX_BITS+
// LEAF_INDEX_BITS) leaf entries (1024 with the defaults); busy stays high
// during the sweep. A request is taken when start is high and busy is low. A
// lookup registers the request, reads the top, middle and leaf entries from
// their RAMs in the READ state and resolves the walk in the RESOLVE state;
// done_o pulses as RESOLVE hands back to idle and busy drops in that same
// cycle, so a new request can be taken while the result shows. An update writes
// its entry at the edge after acceptance, with done_o rising at that same edge.
// Results are shown for exactly one cycle; the receiver cannot stall them.
// leaf_writable may be written through cfg_we_i only while the block is idle.
module three_level_page_table_walker_unit #(
  parameter int TOP_INDEX_BITS  = 2,
  parameter int MID_INDEX_BITS  = 4,
  parameter int LEAF_INDEX_BITS = 4,
  parameter int OFFSET_BITS     = 10,
  parameter int FRAME_BITS      = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic [ptw_pkg::MODE_W-1:0]   mode_i,
  input  logic [ptw_pkg::ADDR_W-1:0]   address_i,
  input  logic                         write_access_i,
  input  logic [ptw_pkg::TABLE_W-1:0]  target_table_i,
  input  logic [ptw_pkg::INDEX_W-1:0]  entry_index_i,
  input  logic [ptw_pkg::VALUE_W-1:0]  entry_value_i,
  output logic                         done_o,
  output logic [ptw_pkg::STATUS_W-1:0] status_o,
  output logic [ptw_pkg::FRAME_W-1:0]  frame_o,
  output logic [ptw_pkg::LEVEL_W-1:0]  fault_level_o,
  output logic [ptw_pkg::PAGE_W-1:0]   fault_page_o,
  output logic                         write_denied_o
);

  ptw_pkg::ptw_cmd_t cmd;
  ptw_pkg::ptw_sts_t sts;

  ptw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ptw_dpath #(
    .TOP_INDEX_BITS  (TOP_INDEX_BITS),
    .MID_INDEX_BITS  (MID_INDEX_BITS),
    .LEAF_INDEX_BITS (LEAF_INDEX_BITS),
    .OFFSET_BITS     (OFFSET_BITS),
    .FRAME_BITS      (FRAME_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .write_access_i (write_access_i),
    .target_table_i (target_table_i),
    .entry_index_i  (entry_index_i),
    .entry_value_i  (entry_value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .frame_o        (frame_o),
    .fault_level_o  (fault_level_o),
    .fault_page_o   (fault_page_o),
    .write_denied_o (write_denied_o)
  );

endmodule
